@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define LBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbp assertion failed");

// next-cycle implication, disabled while reset is low
`define LBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbp assertion failed");

`endif

@@ hdl/lbp_pkg.sv @@
// shared constants and types of the 3x3 local binary pattern block
package lbp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W     = 8;
    localparam int DIM_W     = 11;
    localparam int POS_OUT_W = 10;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    // input row counter also covers the flush row and the final flush item
    localparam int IN_ROW_W  = $clog2(MAX_HEIGHT + 2);
    localparam int LINE_W    = 2 * PIX_W;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // per-item control and position info handed from lbp_ctrl
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] col;
        logic             emit;
        logic [ROW_W-1:0] row_out;
        logic [COL_W-1:0] col_out;
        logic             last;
        logic             top_out;
        logic             bottom_out;
        logic             left_out;
        logic             right_out;
    } item_info_t;

endpackage

@@ hdl/lbp_ctrl.sv @@
// frame position counters, image size registers and per-item role decode
module lbp_ctrl
    import lbp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [DIM_W-1:0] cfg_data,
    input  logic             accept,
    input  logic [PIX_W-1:0] pixel,
    input  logic             pad_item,
    output item_info_t       info
);

    logic [DIM_W-1:0]    width_reg, width_next;
    logic [DIM_W-1:0]    height_reg, height_next;
    logic [COL_W-1:0]    in_col_reg, in_col_next;
    logic [IN_ROW_W-1:0] in_row_reg, in_row_next;
    logic [ROW_W-1:0]    out_row_reg, out_row_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;

    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [DIM_W-1:0] w_last;
    logic             in_col_end;
    logic             out_col_end;
    logic             is_pixel;
    logic             is_final;
    logic             emit;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign w_last      = w_eff - DIM_W'(1);
    assign in_col_end  = (DIM_W'(in_col_reg) == w_last);
    assign out_col_end = (DIM_W'(out_col_reg) == w_last);
    assign is_pixel    = (DIM_W'(in_row_reg) < h_eff);
    // single flush item after the flush row closes the frame
    assign is_final    = (DIM_W'(in_row_reg) == h_eff + DIM_W'(1));
    // a code is due once width+1 items have gone in
    assign emit        = (in_row_reg >= IN_ROW_W'(2))
                      || ((in_row_reg == IN_ROW_W'(1)) && (in_col_reg != '0));

    always_comb
    begin
        info.pixel      = (pad_item || !is_pixel) ? '0 : pixel;
        info.col        = in_col_reg;
        info.emit       = emit;
        info.row_out    = out_row_reg;
        info.col_out    = out_col_reg;
        info.last       = (DIM_W'(out_row_reg) == h_eff - DIM_W'(1)) && out_col_end;
        info.top_out    = (out_row_reg == '0);
        info.bottom_out = ((DIM_W'(out_row_reg) + DIM_W'(1)) >= h_eff);
        info.left_out   = (out_col_reg == '0);
        info.right_out  = out_col_end;
    end

    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_next  = cfg_data;
                REG_IMAGE_HEIGHT: height_next = cfg_data;
                default:          width_next  = width_reg;
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
        end
        else if (accept)
        begin
            if (is_final)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_row_next = '0;
                out_col_next = '0;
            end
            else
            begin
                if (in_col_end)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + IN_ROW_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
                if (emit)
                begin
                    if (out_col_end)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
        end
    end

endmodule

@@ hdl/lbp_line.sv @@
// two line stores in one memory word {middle, upper}, with write-to-read bypass
module lbp_line
    import lbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [COL_W-1:0]  rd_addr,
    input  logic              wr_en,
    input  logic [COL_W-1:0]  wr_addr,
    input  logic [LINE_W-1:0] wr_data,
    output logic [LINE_W-1:0] rd_data
);

    logic [LINE_W-1:0] mem [MAX_WIDTH];
    logic [LINE_W-1:0] mem_q_reg;
    logic [LINE_W-1:0] fwd_data_reg;
    logic              fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // a same-edge write to the read column happens at width 1 and across the frame wrap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_hit_reg <= 1'b0;
        else if (rd_en)
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : mem_q_reg;

endmodule

@@ hdl/lbp_code.sv @@
// 3x3 window shift and neighbor-versus-center code
module lbp_code
    import lbp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [PIX_W-1:0] upper,
    input  logic [PIX_W-1:0] middle,
    input  logic [PIX_W-1:0] pixel,
    input  logic             top_out,
    input  logic             bottom_out,
    input  logic             left_out,
    input  logic             right_out,
    output logic [7:0]       code
);

    // only the two newest columns are kept; the oldest one falls out on a shift
    logic [PIX_W-1:0] win_reg [3][2];
    logic [PIX_W-1:0] nb [8];
    logic [7:0]       outside;
    logic [PIX_W-1:0] centre;

    assign centre = win_reg[1][1];

    always_comb
    begin
        nb[0] = win_reg[0][0];
        nb[1] = win_reg[0][1];
        nb[2] = upper;
        nb[3] = win_reg[1][0];
        nb[4] = middle;
        nb[5] = win_reg[2][0];
        nb[6] = win_reg[2][1];
        nb[7] = pixel;

        outside[0] = top_out || left_out;
        outside[1] = top_out;
        outside[2] = top_out || right_out;
        outside[3] = left_out;
        outside[4] = right_out;
        outside[5] = bottom_out || left_out;
        outside[6] = bottom_out;
        outside[7] = bottom_out || right_out;

        for (int n = 0; n < 8; n++)
            code[7 - n] = outside[n] || !(nb[n] > centre);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= '0;
                win_reg[r][1] <= '0;
            end
        end
        else if (step)
        begin
            win_reg[0][0] <= win_reg[0][1];
            win_reg[1][0] <= win_reg[1][1];
            win_reg[2][0] <= win_reg[2][1];
            win_reg[0][1] <= upper;
            win_reg[1][1] <= middle;
            win_reg[2][1] <= pixel;
        end
    end

endmodule

@@ hdl/local_binary_pattern_3x3.sv @@
// a pixel's code leaves through stage one and the output register, after the beat that is image_width+1 items later
// throughput: one beat per cycle; the only stall is a full output register
// line stores are read at accept and written as the beat leaves stage one, bypassed per column
// reset: asynchronous active low; sizes go to 640x480, counters and window clear
// line store contents are not cleared and only ever feed masked border neighbors
module local_binary_pattern_3x3
    import lbp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [DIM_W-1:0] cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // pixel[7:0]
    input  logic [0:0]       s_tuser,   // pad_item[0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,   // lbp_code[7:0], out_row[17:8], out_col[27:18], zero
    output logic             m_tlast
);

    logic              advance;
    logic              accept;
    item_info_t        info;
    item_info_t        s1_info_reg;
    logic              s1_valid_reg;
    logic [LINE_W-1:0] line_q;
    logic [LINE_W-1:0] line_wr;
    logic              line_we;
    logic [7:0]        code;

    logic              out_valid_reg;
    logic [7:0]        out_code_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic              out_last_reg;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    lbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .accept   (accept),
        .pixel    (s_tdata[PIX_W-1:0]),
        .pad_item (s_tuser[0]),
        .info     (info)
    );

    // middle moves up to upper, the new pixel becomes middle
    assign line_we = s1_valid_reg && advance;
    assign line_wr = {s1_info_reg.pixel, line_q[LINE_W-1:PIX_W]};

    lbp_line u_line (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept),
        .rd_addr(info.col),
        .wr_en  (line_we),
        .wr_addr(s1_info_reg.col),
        .wr_data(line_wr),
        .rd_data(line_q)
    );

    lbp_code u_code (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (line_we),
        .upper     (line_q[PIX_W-1:0]),
        .middle    (line_q[LINE_W-1:PIX_W]),
        .pixel     (s1_info_reg.pixel),
        .top_out   (s1_info_reg.top_out),
        .bottom_out(s1_info_reg.bottom_out),
        .left_out  (s1_info_reg.left_out),
        .right_out (s1_info_reg.right_out),
        .code      (code)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_info_reg  <= info;
            out_code_reg <= code;
            out_row_reg  <= s1_info_reg.row_out;
            out_col_reg  <= s1_info_reg.col_out;
            out_last_reg <= s1_info_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= accept;
            out_valid_reg <= s1_valid_reg && s1_info_reg.emit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0000, POS_OUT_W'(out_col_reg), POS_OUT_W'(out_row_reg), out_code_reg};

endmodule

@@ hdl/lbp_checker.sv @@
// port-level checks for the local binary pattern block, bound to the top level
`include "assert_macros.svh"

module lbp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // a held beat keeps its content
    `LBP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // an empty output register never blocks the input side
    `LBP_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !m_tvalid, s_tready)

    // on the top row the three upper neighbors lie outside and give ones
    `LBP_ASSERT_NOW(a_top_row_bits, clk, rst_n, m_tvalid && (m_tdata[17:8] == 10'd0), m_tdata[7] && m_tdata[6] && m_tdata[5])

    // on the left column the three left neighbors lie outside and give ones
    `LBP_ASSERT_NOW(a_left_col_bits, clk, rst_n, m_tvalid && (m_tdata[27:18] == 10'd0), m_tdata[7] && m_tdata[4] && m_tdata[2])

    // fill bits of the result beat stay zero
    `LBP_ASSERT_NOW(a_fill_zero, clk, rst_n, m_tvalid, m_tdata[31:28] == 4'd0)

endmodule

bind local_binary_pattern_3x3 lbp_checker u_lbp_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);
